### sv/triangle_edge_rasterizer_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the triangle edge rasterizer
// Concurrent property wrappers for the checker file ter_checker.sv.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_EDGE_RASTERIZER_UNIT_DEFINES_SVH
`define TRIANGLE_EDGE_RASTERIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define TER_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ter: same-cycle check failed");

// next-cycle implication
`define TER_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ter: next-cycle check failed");

`endif

### sv/ter_pkg.sv
// ---------------------------------------------------------------------------
// ter_pkg
// Shared types and constants of the triangle edge rasterizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ter_pkg;

   localparam int SCREEN_W  = 64;
   localparam int SCREEN_H  = 36;

   localparam int COORD_W   = 16;
   localparam int ROW_W     = 6;
   localparam int MASK_W    = 64;

   // pixels tested per cycle and the number of chunks that cover a row
   localparam int LANES     = 8;
   localparam int LANE_SH   = $clog2(LANES);
   localparam int CHUNKS    = (SCREEN_W + LANES - 1) / LANES;
   localparam int CHUNK_W   = ROW_W - LANE_SH;

   // shared multiplier and edge accumulators
   localparam int OPND_W    = 18;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int ACC_W     = 40;
   localparam int MUL_STEPS = 8;
   localparam int STEP_W    = 4;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [OPND_W-1:0]  opnd_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [ACC_W-1:0]   acc_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BOX,
      ST_MUL,
      ST_SCAN
   } state_type;

endpackage

`default_nettype wire

### sv/ter_if.sv
// ---------------------------------------------------------------------------
// ter channel interfaces
// Valid/ready channels for triangle transactions and row-mask transactions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ter_req_if;
   logic                valid;
   logic                ready;
   ter_pkg::coord_type  v0_x;
   ter_pkg::coord_type  v0_y;
   ter_pkg::coord_type  v1_x;
   ter_pkg::coord_type  v1_y;
   ter_pkg::coord_type  v2_x;
   ter_pkg::coord_type  v2_y;

   modport source (output valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, input ready);
   modport sink   (input valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, output ready);
endinterface

interface ter_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ter_pkg::ROW_W-1:0]     row_index;
   logic [ter_pkg::MASK_W-1:0]    row_mask;
   logic                          last_row;

   modport source (output valid, row_index, row_mask, last_row, input ready);
   modport sink   (input valid, row_index, row_mask, last_row, output ready);
endinterface

`default_nettype wire

### sv/triangle_edge_rasterizer_unit.sv
// ---------------------------------------------------------------------------
// triangle_edge_rasterizer_unit
// Half-space rasterizer: one triangle in, one coverage mask per clipped row.
// ---------------------------------------------------------------------------
//  channel  dir  payload                                  handshake
//  req      in   v0_x v0_y v1_x v1_y v2_x v2_y            valid/ready
//  rsp      out  row_index row_mask last_row              valid/ready
//
//  Per triangle: a bounding-box state, then a run on the shared 18x18
//  multiplier (edge constants and area), then a scan of each clipped row,
//  one 8-pixel chunk per cycle while the output is not stalled. A triangle
//  off screen goes from the bounding-box state straight back to idle.
//  req.ready is high only while idle. Reset is synchronous and clears control.
//  A finished row waits in its last chunk until the output register is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_edge_rasterizer_unit (
   input  logic       clock,
   input  logic       reset,
   ter_req_if.sink    req,
   ter_rsp_if.source  rsp
);

   localparam int COORD_W = ter_pkg::COORD_W;
   localparam int ROW_W   = ter_pkg::ROW_W;
   localparam int LANES   = ter_pkg::LANES;
   localparam int LANE_SH = ter_pkg::LANE_SH;
   localparam int CHUNK_W = ter_pkg::CHUNK_W;
   localparam int ACC_W   = ter_pkg::ACC_W;
   localparam int STEP_W  = ter_pkg::STEP_W;
   localparam int MASK_W  = ter_pkg::MASK_W;

   function automatic ter_pkg::coord_type min3(ter_pkg::coord_type a, ter_pkg::coord_type b,
                                               ter_pkg::coord_type c);
      ter_pkg::coord_type m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic ter_pkg::coord_type max3(ter_pkg::coord_type a, ter_pkg::coord_type b,
                                               ter_pkg::coord_type c);
      ter_pkg::coord_type m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic ter_pkg::opnd_type sx(ter_pkg::coord_type v);
      return ter_pkg::opnd_type'(v);
   endfunction

   // registers
   ter_pkg::state_type  state_ff, state_in;
   ter_pkg::coord_type  vx_ff [3];
   ter_pkg::coord_type  vx_in [3];
   ter_pkg::coord_type  vy_ff [3];
   ter_pkg::coord_type  vy_in [3];
   logic [ROW_W-1:0]    bx0_ff, bx0_in, bx1_ff, bx1_in;
   logic [ROW_W-1:0]    row_ff, row_in, by1_ff, by1_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   ter_pkg::prod_type   prod_ff, prod_in;
   ter_pkg::acc_type    base_ff [3];
   ter_pkg::acc_type    base_in [3];
   ter_pkg::acc_type    chunk_ff [3];
   ter_pkg::acc_type    chunk_in [3];
   ter_pkg::acc_type    area_ff, area_in;
   logic [CHUNK_W-1:0]  cidx_ff, cidx_in;
   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [MASK_W-1:0]   rsp_mask_ff, rsp_mask_in;
   logic                rsp_last_ff, rsp_last_in;

   // control
   logic                accept;
   logic                mul_issue;
   logic                mul_done;
   logic                last_chunk;
   logic                out_free;
   logic                row_emit;
   logic                row_last;

   // box
   ter_pkg::coord_type  x_lo, x_hi, y_lo, y_hi;
   logic                box_empty;

   // multiplier operands and accumulate target
   ter_pkg::opnd_type   op_a, op_b;
   logic [STEP_W-1:0]   acc_step;
   logic [1:0]          acc_edge;
   ter_pkg::acc_type    prod_ext;

   // scan
   ter_pkg::acc_type    rstep [3];
   ter_pkg::acc_type    cstep [3];
   logic                area_pos, area_neg;
   logic [LANES-1:0]    chunk_bits;
   logic [MASK_W-1:0]   mask_cur;

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ter_pkg::ST_IDLE: begin
            if (req.valid) state_in = ter_pkg::ST_BOX;
         end
         ter_pkg::ST_BOX: begin
            state_in = box_empty ? ter_pkg::ST_IDLE : ter_pkg::ST_MUL;
         end
         ter_pkg::ST_MUL: begin
            if (mul_done) state_in = ter_pkg::ST_SCAN;
         end
         ter_pkg::ST_SCAN: begin
            if (row_emit && row_last) state_in = ter_pkg::ST_IDLE;
         end
         default: state_in = ter_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // control outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req.ready  = 1'b0;
      accept     = 1'b0;
      mul_issue  = 1'b0;
      mul_done   = 1'b0;
      row_emit   = 1'b0;
      last_chunk = (cidx_ff == CHUNK_W'(ter_pkg::CHUNKS - 1));
      out_free   = !rsp_valid_ff || rsp.ready;
      row_last   = (row_ff == by1_ff);
      case (state_ff)
         ter_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            accept    = req.valid;
         end
         ter_pkg::ST_MUL: begin
            mul_issue = (step_ff < STEP_W'(ter_pkg::MUL_STEPS));
            mul_done  = (step_ff == STEP_W'(ter_pkg::MUL_STEPS));
         end
         ter_pkg::ST_SCAN: begin
            row_emit = last_chunk && out_free;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // bounding box and clip
   // ---------------------------------------------------------------------
   always_comb begin
      x_lo = min3(vx_ff[0], vx_ff[1], vx_ff[2]);
      x_hi = max3(vx_ff[0], vx_ff[1], vx_ff[2]);
      y_lo = min3(vy_ff[0], vy_ff[1], vy_ff[2]);
      y_hi = max3(vy_ff[0], vy_ff[1], vy_ff[2]);
      box_empty = (x_hi < 0) || (x_lo > ter_pkg::coord_type'(ter_pkg::SCREEN_W - 1)) ||
                  (y_hi < 0) || (y_lo > ter_pkg::coord_type'(ter_pkg::SCREEN_H - 1));
   end

   // ---------------------------------------------------------------------
   // multiplier operand select
   // Even steps: DX * (by0 - ay); odd steps: DY * ax. Steps 6/7 form the area.
   // ---------------------------------------------------------------------
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         4'd0: begin op_a = sx(vx_ff[2]) - sx(vx_ff[1]);
                     op_b = ter_pkg::opnd_type'(row_ff) - sx(vy_ff[1]); end
         4'd1: begin op_a = sx(vy_ff[2]) - sx(vy_ff[1]); op_b = sx(vx_ff[1]); end
         4'd2: begin op_a = sx(vx_ff[0]) - sx(vx_ff[2]);
                     op_b = ter_pkg::opnd_type'(row_ff) - sx(vy_ff[2]); end
         4'd3: begin op_a = sx(vy_ff[0]) - sx(vy_ff[2]); op_b = sx(vx_ff[2]); end
         4'd4: begin op_a = sx(vx_ff[1]) - sx(vx_ff[0]);
                     op_b = ter_pkg::opnd_type'(row_ff) - sx(vy_ff[0]); end
         4'd5: begin op_a = sx(vy_ff[1]) - sx(vy_ff[0]); op_b = sx(vx_ff[0]); end
         4'd6: begin op_a = sx(vx_ff[1]) - sx(vx_ff[0]);
                     op_b = sx(vy_ff[2]) - sx(vy_ff[0]); end
         4'd7: begin op_a = sx(vy_ff[1]) - sx(vy_ff[0]);
                     op_b = sx(vx_ff[2]) - sx(vx_ff[0]); end
         default: begin
         end
      endcase
   end

   assign acc_step = step_ff - STEP_W'(1);
   assign acc_edge = acc_step[2:1];
   assign prod_ext = ter_pkg::acc_type'(prod_ff);

   // ---------------------------------------------------------------------
   // per-edge steps: +DX per row, -DY per pixel
   // ---------------------------------------------------------------------
   always_comb begin
      rstep[0] = ter_pkg::acc_type'(vx_ff[2]) - ter_pkg::acc_type'(vx_ff[1]);
      rstep[1] = ter_pkg::acc_type'(vx_ff[0]) - ter_pkg::acc_type'(vx_ff[2]);
      rstep[2] = ter_pkg::acc_type'(vx_ff[1]) - ter_pkg::acc_type'(vx_ff[0]);
      cstep[0] = ter_pkg::acc_type'(vy_ff[1]) - ter_pkg::acc_type'(vy_ff[2]);
      cstep[1] = ter_pkg::acc_type'(vy_ff[2]) - ter_pkg::acc_type'(vy_ff[0]);
      cstep[2] = ter_pkg::acc_type'(vy_ff[0]) - ter_pkg::acc_type'(vy_ff[1]);
   end

   assign area_neg = area_ff[ACC_W-1];
   assign area_pos = !area_ff[ACC_W-1] && (area_ff != '0);

   // ---------------------------------------------------------------------
   // coverage of one 8-pixel chunk
   // ---------------------------------------------------------------------
   always_comb begin : chunk_eval
      logic [ROW_W-1:0]  px;
      ter_pkg::acc_type  w;
      logic              all_pos;
      logic              all_neg;
      for (int j = 0; j < LANES; j++) begin
         px      = {cidx_ff, LANE_SH'(j)};
         all_pos = 1'b1;
         all_neg = 1'b1;
         for (int e = 0; e < 3; e++) begin
            w = chunk_ff[e] + cstep[e] * $signed(ACC_W'(j));
            if (w[ACC_W-1]) all_pos = 1'b0;
            if (!w[ACC_W-1] && (w != '0)) all_neg = 1'b0;
         end
         chunk_bits[j] = (px >= bx0_ff) && (px <= bx1_ff) &&
                         ((area_pos && all_pos) || (area_neg && all_neg));
      end
      mask_cur = mask_ff;
      mask_cur[{cidx_ff, LANE_SH'(0)} +: LANES] = chunk_bits;
   end

   // ---------------------------------------------------------------------
   // datapath next values
   // ---------------------------------------------------------------------
   always_comb begin
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      bx0_in       = bx0_ff;
      bx1_in       = bx1_ff;
      row_in       = row_ff;
      by1_in       = by1_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      base_in      = base_ff;
      chunk_in     = chunk_ff;
      area_in      = area_ff;
      cidx_in      = cidx_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_row_in   = rsp_row_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_last_in  = rsp_last_ff;

      if (accept) begin
         vx_in[0] = req.v0_x;
         vy_in[0] = req.v0_y;
         vx_in[1] = req.v1_x;
         vy_in[1] = req.v1_y;
         vx_in[2] = req.v2_x;
         vy_in[2] = req.v2_y;
      end

      if (state_ff == ter_pkg::ST_BOX) begin
         // only meaningful when the box is not empty
         bx0_in  = x_lo[COORD_W-1] ? '0 : x_lo[ROW_W-1:0];
         bx1_in  = (x_hi > ter_pkg::coord_type'(ter_pkg::SCREEN_W - 1)) ?
                   ROW_W'(ter_pkg::SCREEN_W - 1) : x_hi[ROW_W-1:0];
         row_in  = y_lo[COORD_W-1] ? '0 : y_lo[ROW_W-1:0];
         by1_in  = (y_hi > ter_pkg::coord_type'(ter_pkg::SCREEN_H - 1)) ?
                   ROW_W'(ter_pkg::SCREEN_H - 1) : y_hi[ROW_W-1:0];
         step_in = '0;
      end

      if (state_ff == ter_pkg::ST_MUL) begin
         step_in = step_ff + STEP_W'(1);
         if (mul_issue) prod_in = op_a * op_b;
         if (step_ff != '0) begin
            if (acc_edge == 2'd3) begin
               area_in = acc_step[0] ? (area_ff - prod_ext) : prod_ext;
            end else begin
               base_in[acc_edge] = acc_step[0] ? (base_ff[acc_edge] + prod_ext) : prod_ext;
            end
         end
         if (mul_done) begin
            chunk_in = base_ff;
            cidx_in  = '0;
            mask_in  = '0;
         end
      end

      if (state_ff == ter_pkg::ST_SCAN) begin
         if (!last_chunk) begin
            mask_in = mask_cur;
            cidx_in = cidx_ff + CHUNK_W'(1);
            for (int e = 0; e < 3; e++) begin
               chunk_in[e] = chunk_ff[e] + (cstep[e] <<< LANE_SH);
            end
         end else if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_row_in   = row_ff;
            rsp_mask_in  = mask_cur;
            rsp_last_in  = row_last;
            if (!row_last) begin
               row_in  = row_ff + ROW_W'(1);
               cidx_in = '0;
               mask_in = '0;
               for (int e = 0; e < 3; e++) begin
                  base_in[e]  = base_ff[e] + rstep[e];
                  chunk_in[e] = base_ff[e] + rstep[e];
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ter_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      bx0_ff      <= bx0_in;
      bx1_ff      <= bx1_in;
      row_ff      <= row_in;
      by1_ff      <= by1_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      base_ff     <= base_in;
      chunk_ff    <= chunk_in;
      area_ff     <= area_in;
      cidx_ff     <= cidx_in;
      mask_ff     <= mask_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.row_index = rsp_row_ff;
   assign rsp.row_mask  = rsp_mask_ff;
   assign rsp.last_row  = rsp_last_ff;

endmodule

`default_nettype wire

### sv/ter_checker.sv
// ---------------------------------------------------------------------------
// ter_checker
// Port-level checks of the triangle edge rasterizer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "triangle_edge_rasterizer_unit_defines.svh"

module ter_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ter_pkg::ROW_W-1:0]     rsp_row_index,
   input logic [ter_pkg::MASK_W-1:0]    rsp_row_mask,
   input logic                          rsp_last_row
);

   localparam int ROW_W = ter_pkg::ROW_W;

   // a stalled transaction keeps its payload
   `TER_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row_index) && $stable(rsp_row_mask) && $stable(rsp_last_row))

   // one triangle at a time
   `TER_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a non-final row on the output means the triangle is still being scanned
   `TER_ASSERT_NOW(a_busy_mid_triangle, clock, reset, rsp_valid && !rsp_last_row, !req_ready)

   `TER_ASSERT_NOW(a_row_on_screen, clock, reset, rsp_valid, rsp_row_index <= ROW_W'(ter_pkg::SCREEN_H - 1))

endmodule

bind triangle_edge_rasterizer_unit ter_checker u_ter_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_row_index (rsp.row_index),
   .rsp_row_mask  (rsp.row_mask),
   .rsp_last_row  (rsp.last_row)
);

`default_nettype wire

### tb/sv/tb_triangle_edge_rasterizer_unit.sv
// ---------------------------------------------------------------------------
// tb_triangle_edge_rasterizer_unit
// Self-checking bench for the half-space rasterizer. Triangles go in on the
// req channel and every row-mask transaction on rsp is checked against a
// scoreboard that rasterizes each accepted triangle with exact 64-bit
// integer edge functions. The bench covers directed corner cases, random
// near-screen, collinear and full-range triangles, random idling on both
// channels, a long output stall and drain pauses.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_edge_rasterizer_unit;

   typedef struct {
      ter_pkg::coord_type v0_x;
      ter_pkg::coord_type v0_y;
      ter_pkg::coord_type v1_x;
      ter_pkg::coord_type v1_y;
      ter_pkg::coord_type v2_x;
      ter_pkg::coord_type v2_y;
   } triangle_type;

   typedef struct {
      logic [ter_pkg::ROW_W-1:0]  row_index;
      logic [ter_pkg::MASK_W-1:0] row_mask;
      logic                       last_row;
   } row_cov_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ter_req_if req_ch ();
   ter_rsp_if rsp_ch ();

   triangle_edge_rasterizer_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   row_cov_type expected_rows[$];
   int          mismatch_count = 0;
   bit          no_idle        = 1'b0;
   int          stall_request  = 0;
   int          stall_left     = 0;

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.v0_x  = '0;
      req_ch.v0_y  = '0;
      req_ch.v1_x  = '0;
      req_ch.v1_y  = '0;
      req_ch.v2_x  = '0;
      req_ch.v2_y  = '0;
      rsp_ch.ready = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Scoreboard model
   // -------------------------------------------------------------------------
   function automatic longint orient(input longint ax, ay, bx, by, cx, cy);
      return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
   endfunction

   function automatic longint min3(input longint a, b, c);
      longint m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic longint max3(input longint a, b, c);
      longint m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic void rasterize_triangle(input triangle_type t);
      longint                     x0, y0, x1, y1, x2, y2;
      longint                     left, top, right, bottom, area;
      longint                     px, py, w0, w1, w2;
      logic [ter_pkg::MASK_W-1:0] mask;
      row_cov_type                r;
      x0 = t.v0_x;
      y0 = t.v0_y;
      x1 = t.v1_x;
      y1 = t.v1_y;
      x2 = t.v2_x;
      y2 = t.v2_y;
      left   = min3(x0, x1, x2);
      top    = min3(y0, y1, y2);
      right  = max3(x0, x1, x2);
      bottom = max3(y0, y1, y2);
      if (left < 0) left = 0;
      if (top < 0) top = 0;
      if (right > ter_pkg::SCREEN_W - 1) right = ter_pkg::SCREEN_W - 1;
      if (bottom > ter_pkg::SCREEN_H - 1) bottom = ter_pkg::SCREEN_H - 1;
      area = orient(x0, y0, x1, y1, x2, y2);
      // clipped box empty: triangle produces no transactions
      if (left > right || top > bottom) return;
      for (py = top; py <= bottom; py++) begin
         mask = '0;
         if (area != 0) begin
            for (px = left; px <= right; px++) begin
               w0 = orient(x1, y1, x2, y2, px, py);
               w1 = orient(x2, y2, x0, y0, px, py);
               w2 = orient(x0, y0, x1, y1, px, py);
               if (area > 0 ? (w0 >= 0 && w1 >= 0 && w2 >= 0)
                            : (w0 <= 0 && w1 <= 0 && w2 <= 0))
                  mask[px] = 1'b1;
            end
         end
         r.row_index = py[ter_pkg::ROW_W-1:0];
         r.row_mask  = mask;
         r.last_row  = (py == bottom);
         expected_rows.push_back(r);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("%0t ns: ERROR %s", $time, msg);
   endtask

   always @(posedge clock) begin : check_rows
      row_cov_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rows.size() == 0) begin
            report_mismatch($sformatf("row transaction with nothing pending: row %0d mask %h",
                                      rsp_ch.row_index, rsp_ch.row_mask));
         end else begin
            want = expected_rows.pop_front();
            if (rsp_ch.row_index !== want.row_index)
               report_mismatch($sformatf("row_index got %0d expected %0d",
                                         rsp_ch.row_index, want.row_index));
            if (rsp_ch.row_mask !== want.row_mask)
               report_mismatch($sformatf("row_mask row %0d got %h expected %h",
                                         want.row_index, rsp_ch.row_mask, want.row_mask));
            if (rsp_ch.last_row !== want.last_row)
               report_mismatch($sformatf("last_row row %0d got %b expected %b",
                                         want.row_index, rsp_ch.last_row, want.last_row));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random backpressure, plus a counted hold-off on request
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_request != 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (no_idle) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= 26);
      end
   end

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------
   // Called at a falling edge; returns at a falling edge with valid still high
   // so back-to-back transactions keep valid asserted.
   task automatic send_triangle(input triangle_type t);
      while (!no_idle && $urandom_range(0, 99) < 26) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.v0_x  <= t.v0_x;
      req_ch.v0_y  <= t.v0_y;
      req_ch.v1_x  <= t.v1_x;
      req_ch.v1_y  <= t.v1_y;
      req_ch.v2_x  <= t.v2_x;
      req_ch.v2_y  <= t.v2_y;
      do
         @(posedge clock);
      while (!req_ch.ready);
      rasterize_triangle(t);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (expected_rows.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_no_idle(input bit on);
      @(posedge clock);
      no_idle = on;
      @(negedge clock);
   endtask

   function automatic triangle_type tri_of(input int ax, ay, bx, by, cx, cy);
      triangle_type t;
      t.v0_x = ter_pkg::coord_type'(ax);
      t.v0_y = ter_pkg::coord_type'(ay);
      t.v1_x = ter_pkg::coord_type'(bx);
      t.v1_y = ter_pkg::coord_type'(by);
      t.v2_x = ter_pkg::coord_type'(cx);
      t.v2_y = ter_pkg::coord_type'(cy);
      return t;
   endfunction

   function automatic int jitter(input int c, input int span);
      return c + int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Mostly small triangles so most items take few rows
   function automatic triangle_type near_screen_triangle();
      int cx, cy, span;
      cx = int'($urandom_range(0, 84)) - 10;
      cy = int'($urandom_range(0, 56)) - 10;
      if ($urandom_range(0, 99) < 75)
         span = int'($urandom_range(1, 10));
      else
         span = int'($urandom_range(11, 48));
      return tri_of(jitter(cx, span), jitter(cy, span), jitter(cx, span),
                    jitter(cy, span), jitter(cx, span), jitter(cy, span));
   endfunction

   function automatic triangle_type collinear_triangle();
      int bx, by, dx, dy, k1, k2;
      bx = int'($urandom_range(0, 84)) - 10;
      by = int'($urandom_range(0, 56)) - 10;
      dx = int'($urandom_range(0, 16)) - 8;
      dy = int'($urandom_range(0, 16)) - 8;
      k1 = int'($urandom_range(0, 6)) - 3;
      k2 = int'($urandom_range(0, 6)) - 3;
      return tri_of(bx, by, bx + k1 * dx, by + k1 * dy, bx + k2 * dx, by + k2 * dy);
   endfunction

   function automatic triangle_type full_range_triangle();
      return tri_of(int'($urandom()), int'($urandom()), int'($urandom()),
                    int'($urandom()), int'($urandom()), int'($urandom()));
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   task automatic test_directed();
      triangle_type cases[$];
      cases.push_back(tri_of(2, 2, 10, 2, 2, 10));            // positive area
      cases.push_back(tri_of(2, 2, 2, 10, 10, 2));            // negative area
      cases.push_back(tri_of(0, 0, 20, 10, 40, 20));          // collinear, zero area
      cases.push_back(tri_of(5, 5, 5, 5, 5, 5));              // single point
      cases.push_back(tri_of(63, 35, 63, 35, 63, 35));        // point at far corner
      cases.push_back(tri_of(-30, 4, -1, 10, -5, 30));        // off screen left
      cases.push_back(tri_of(64, 4, 90, 10, 70, 30));         // off screen right
      cases.push_back(tri_of(4, -30, 40, -1, 20, -9));        // off screen top
      cases.push_back(tri_of(4, 36, 40, 50, 20, 40));         // off screen bottom
      cases.push_back(tri_of(-32768, -32768, -32768, -32768, -32768, -32768));
      cases.push_back(tri_of(32767, 32767, 32767, 32767, 32767, 32767));
      cases.push_back(tri_of(-32768, -32768, 32767, -32768, -32768, 32767));
      cases.push_back(tri_of(32767, 32767, -32768, 32767, 32767, -32768));
      cases.push_back(tri_of(-32768, 0, 32767, 35, 0, -32768));
      cases.push_back(tri_of(0, 0, 63, 0, 0, 35));            // edges on screen border
      cases.push_back(tri_of(0, 0, 0, 35, 63, 0));            // same, other winding
      cases.push_back(tri_of(63, 35, 40, 35, 63, 20));        // touches bottom right
      cases.push_back(tri_of(0, 0, 63, 0, 30, 0));            // flat on row 0
      cases.push_back(tri_of(10, 0, 11, 35, 10, 35));         // thin sliver
      cases.push_back(tri_of(50, 5, 100, 10, 55, 20));        // clipped on the right
      cases.push_back(tri_of(0, 35, 63, 35, 31, 0));
      cases.push_back(tri_of(-5, -5, 70, 12, 20, 44));        // clipped on all sides
      foreach (cases[i])
         send_triangle(cases[i]);
      wait_drained();
   endtask

   task automatic test_random_near(input int count);
      repeat (count)
         send_triangle(near_screen_triangle());
   endtask

   task automatic test_collinear(input int count);
      repeat (count)
         send_triangle(collinear_triangle());
   endtask

   task automatic test_full_range(input int count);
      repeat (count)
         send_triangle(full_range_triangle());
   endtask

   task automatic test_no_idle_stream(input int count);
      set_no_idle(1'b1);
      repeat (count)
         send_triangle(near_screen_triangle());
      set_no_idle(1'b0);
   endtask

   // Receiver holds off while the sender keeps offering, so the block stalls
   task automatic test_output_stall();
      @(posedge clock);
      stall_request = 300;
      @(negedge clock);
      send_triangle(tri_of(0, 0, 40, 3, 10, 12));
      send_triangle(tri_of(20, 30, 60, 35, 5, 20));
      repeat (6)
         send_triangle(near_screen_triangle());
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_near(150);
      test_collinear(30);
      wait_drained();
      test_output_stall();
      test_no_idle_stream(40);
      test_full_range(50);
      test_random_near(130);
      wait_drained();
      repeat (40) @(negedge clock);

      if (expected_rows.size() != 0)
         report_mismatch($sformatf("%0d row transactions never arrived",
                                   expected_rows.size()));
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/ter_pkg.sv
sv/ter_if.sv
sv/triangle_edge_rasterizer_unit.sv
sv/ter_checker.sv
tb/sv/tb_triangle_edge_rasterizer_unit.sv
